/* sv/csr_neighbor_sampler_macros.svh */
// Assertion helpers shared by the sampler RTL.
`ifndef CSR_NEIGHBOR_SAMPLER_MACROS_SVH
`define CSR_NEIGHBOR_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CSR_NS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CSR_NS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/csr_ns_pkg.sv */
`default_nettype none
package csr_ns_pkg;

   localparam int NODES      = 1024;
   localparam int EDGES      = 8192;
   localparam int MAX_SAMPLE = 64;

   localparam int OFF_DEPTH = NODES + 1;
   localparam int OFF_AW    = $clog2(OFF_DEPTH);
   localparam int EDGE_AW   = $clog2(EDGES);

   localparam int CMD_W     = 2;
   localparam int IDX_W     = 14;
   localparam int VAL_W     = 14;
   localparam int NODE_W    = 10;
   localparam int NB_W      = 10;
   localparam int CNT_W     = 7;
   localparam int STS_W     = 2;
   localparam int SEED_W    = 32;
   localparam int RND_W     = 31;
   localparam int REM_W     = 14;
   localparam int CSR_IDX_W = 2;
   localparam int STEP_W    = 5;

   localparam logic [CMD_W-1:0] CMD_WR_OFFSET   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WR_NEIGHBOR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SAMPLE      = 2'd2;

   localparam logic [STS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
   localparam logic [STS_W-1:0] STS_RANGE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_DRAW_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEED       = 2'd1;

   localparam logic [CNT_W-1:0]  DRAW_LIMIT_RESET = 7'd16;
   localparam logic [SEED_W-1:0] SEED_RESET       = 32'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OFF0,
      ST_OFF1,
      ST_OFF2,
      ST_CHECK,
      ST_STAT,
      ST_DRD,
      ST_DWT,
      ST_COPY,
      ST_SRNG,
      ST_SDIV,
      ST_SRDA,
      ST_SRDB,
      ST_SEMIT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [RND_W-1:0] dividend;
      logic [REM_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [REM_W-1:0] rem;
   } mod_rsp_type;

   function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] s);
      logic [SEED_W-1:0] x;
      x = s;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
   endfunction

endpackage
`default_nettype wire

/* sv/csr_ns_if.sv */
`default_nettype none
interface csr_ns_req_if;
   logic                         valid;
   logic                         ready;
   logic [csr_ns_pkg::CMD_W-1:0]  command;
   logic [csr_ns_pkg::IDX_W-1:0]  index;
   logic [csr_ns_pkg::VAL_W-1:0]  value;
   logic [csr_ns_pkg::NODE_W-1:0] node;
   modport source (output valid, command, index, value, node, input ready);
   modport sink (input valid, command, index, value, node, output ready);
endinterface

interface csr_ns_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [csr_ns_pkg::NB_W-1:0]  neighbor;
   logic [csr_ns_pkg::CNT_W-1:0] count;
   logic [csr_ns_pkg::STS_W-1:0] status;
   logic                         last;
   modport source (output valid, neighbor, count, status, last, input ready);
   modport sink (input valid, neighbor, count, status, last, output ready);
endinterface

interface csr_ns_csr_if;
   logic                             valid;
   logic                             ready;
   logic [csr_ns_pkg::CSR_IDX_W-1:0] index;
   logic [csr_ns_pkg::SEED_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/csr_neighbor_sampler.sv */
// One request at a time: write requests free the block on the next cycle, and a sample
// request holds it until its last result is loaded into the output register.
// A sample reads two offsets and classifies the node in OFF0, OFF1, OFF2 and CHECK after acceptance; a status
// result then goes out from STAT, and a small node streams its neighbors one at a time through DRD and DWT.
// A large node copies its degree entries to scratch, then runs as many steps as the clamped draw limit through SRNG,
// SDIV (bit-serial remainder unit), SRDA, SRDB, SEMIT; results wait for a free output slot. Reset is synchronous.
`default_nettype none
`include "csr_neighbor_sampler_macros.svh"
module csr_neighbor_sampler (
   input wire logic     clock,
   input wire logic     reset,
   csr_ns_req_if.sink   req_ch,
   csr_ns_rsp_if.source rsp_ch,
   csr_ns_csr_if.sink   csr_ch
);
   import csr_ns_pkg::*;

   // Sequencer and per-request registers.
   state_type         state_ff, state_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [IDX_W-1:0]  begin_ff, begin_in;
   logic [IDX_W-1:0]  end_ff, end_in;
   logic [IDX_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  pick_ff, pick_in;
   logic [NB_W-1:0]   a_ff, a_in;
   logic              copy_v_ff, copy_v_in;
   logic [EDGE_AW-1:0] cw_addr_ff, cw_addr_in;
   logic [STS_W-1:0]  stat_ff, stat_in;
   logic [SEED_W-1:0] rng_ff, rng_in;
   logic [CNT_W-1:0]  draw_limit_ff, draw_limit_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NB_W-1:0]   rsp_nb_ff, rsp_nb_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic [STS_W-1:0]  rsp_st_ff, rsp_st_in;
   logic              rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic               off_we, off_re;
   logic [OFF_AW-1:0]  off_waddr, off_raddr;
   logic [IDX_W-1:0]   off_rdata;
   logic               nb_we, nb_re;
   logic [EDGE_AW-1:0] nb_waddr, nb_raddr;
   logic [NB_W-1:0]    nb_rdata;
   logic               sc_we, sc_re;
   logic [EDGE_AW-1:0] sc_waddr, sc_raddr;
   logic [NB_W-1:0]    sc_wdata, sc_rdata;

   mod_req_type mod_req;
   mod_rsp_type mod_rsp;

   logic              req_acc, can_put, bad_range, copy_rd;
   logic [CNT_W-1:0]  k_cmb;
   logic [IDX_W-1:0]  nb_sum, i_ext, left_cnt;
   logic [OFF_AW-1:0] node_x;
   logic [SEED_W-1:0] rng_next;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   // The output slot is free when empty or when its held response is taken this cycle.
   assign can_put      = !rsp_valid_ff || rsp_ch.ready;

   assign node_x    = OFF_AW'(node_ff);
   assign nb_sum    = begin_ff + j_ff;
   assign i_ext     = IDX_W'(i_ff);
   assign left_cnt  = cap_ff - i_ext;
   assign rng_next  = xorshift32(rng_ff);
   assign bad_range = (end_ff < begin_ff) || (end_ff > IDX_W'(EDGES));
   assign copy_rd   = (j_ff < cap_ff);

   // Draw limit clamp: zero acts as one, anything above the maximum as the maximum.
   always_comb begin
      if (draw_limit_ff == '0) begin
         k_cmb = CNT_W'(1);
      end else if (draw_limit_ff > CNT_W'(MAX_SAMPLE)) begin
         k_cmb = CNT_W'(MAX_SAMPLE);
      end else begin
         k_cmb = draw_limit_ff;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_ch.command == CMD_SAMPLE)) begin
               state_in = ST_OFF0;
            end
         end
         ST_OFF0: state_in = ST_OFF1;
         ST_OFF1: state_in = ST_OFF2;
         ST_OFF2: state_in = ST_CHECK;
         ST_CHECK: begin
            if (bad_range || (end_ff == begin_ff)) begin
               state_in = ST_STAT;
            end else if ((end_ff - begin_ff) <= IDX_W'(k_cmb)) begin
               state_in = ST_DRD;
            end else begin
               state_in = ST_COPY;
            end
         end
         ST_STAT: begin
            if (can_put) begin
               state_in = ST_IDLE;
            end
         end
         ST_DRD: state_in = ST_DWT;
         ST_DWT: begin
            if (can_put) begin
               state_in = (IDX_W'(j_ff + 1'b1) == cap_ff) ? ST_IDLE : ST_DRD;
            end
         end
         ST_COPY: begin
            if (!copy_rd && !copy_v_ff) begin
               state_in = ST_SRNG;
            end
         end
         ST_SRNG: state_in = ST_SDIV;
         ST_SDIV: begin
            if (mod_rsp.done) begin
               state_in = ST_SRDA;
            end
         end
         ST_SRDA: state_in = ST_SRDB;
         ST_SRDB: state_in = ST_SEMIT;
         ST_SEMIT: begin
            if (can_put) begin
               state_in = (CNT_W'(i_ff + 1'b1) == k_ff) ? ST_IDLE : ST_SRNG;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory controls and output register.
   always_comb begin
      node_in       = node_ff;
      begin_in      = begin_ff;
      end_in        = end_ff;
      cap_in        = cap_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      i_in          = i_ff;
      pick_in       = pick_ff;
      a_in          = a_ff;
      copy_v_in     = 1'b0;
      cw_addr_in    = cw_addr_ff;
      stat_in       = stat_ff;
      rng_in        = rng_ff;
      draw_limit_in = draw_limit_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_nb_in    = rsp_nb_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_last_in  = rsp_last_ff;

      off_we    = 1'b0;
      off_waddr = req_ch.index[OFF_AW-1:0];
      off_re    = 1'b0;
      off_raddr = node_x;
      nb_we     = 1'b0;
      nb_waddr  = req_ch.index[EDGE_AW-1:0];
      nb_re     = 1'b0;
      nb_raddr  = nb_sum[EDGE_AW-1:0];
      sc_we     = 1'b0;
      sc_waddr  = cw_addr_ff;
      sc_wdata  = nb_rdata;
      sc_re     = 1'b0;
      sc_raddr  = i_ext[EDGE_AW-1:0];

      mod_req.start    = 1'b0;
      mod_req.dividend = rng_next[SEED_W-1:1];
      mod_req.divisor  = left_cnt;

      // The user must issue configuration writes only while the block is idle; the block itself does not enforce it.
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_DRAW_LIMIT: draw_limit_in = csr_ch.data[CNT_W-1:0];
            REG_SEED:       rng_in = csr_ch.data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               node_in = req_ch.node;
               case (req_ch.command)
                  CMD_WR_OFFSET:   off_we = (req_ch.index <= IDX_W'(NODES));
                  CMD_WR_NEIGHBOR: nb_we = (req_ch.index < IDX_W'(EDGES));
                  default: ;
               endcase
            end
         end
         ST_OFF0: begin
            off_re = 1'b1;
         end
         ST_OFF1: begin
            off_re    = 1'b1;
            off_raddr = node_x + OFF_AW'(1);
            begin_in  = off_rdata;
         end
         ST_OFF2: begin
            end_in = off_rdata;
         end
         ST_CHECK: begin
            cap_in  = end_ff - begin_ff;
            k_in    = k_cmb;
            j_in    = '0;
            stat_in = bad_range ? STS_RANGE : STS_EMPTY;
         end
         ST_STAT: begin
            if (can_put) begin
               rsp_valid_in = 1'b1;
               rsp_nb_in    = '0;
               rsp_cnt_in   = '0;
               rsp_st_in    = stat_ff;
               rsp_last_in  = 1'b1;
            end
         end
         ST_DRD: begin
            nb_re = 1'b1;
         end
         ST_DWT: begin
            if (can_put) begin
               rsp_valid_in = 1'b1;
               rsp_nb_in    = nb_rdata;
               rsp_cnt_in   = cap_ff[CNT_W-1:0];
               rsp_st_in    = STS_OK;
               rsp_last_in  = (IDX_W'(j_ff + 1'b1) == cap_ff);
               j_in         = j_ff + 1'b1;
            end
         end
         ST_COPY: begin
            // Read pipeline: the entry read in one cycle is written the next.
            nb_re      = copy_rd;
            copy_v_in  = copy_rd;
            cw_addr_in = j_ff[EDGE_AW-1:0];
            sc_we      = copy_v_ff;
            if (copy_rd) begin
               j_in = j_ff + 1'b1;
            end
            i_in = '0;
         end
         ST_SRNG: begin
            rng_in        = rng_next;
            mod_req.start = 1'b1;
         end
         ST_SDIV: begin
            if (mod_rsp.done) begin
               pick_in = i_ext + mod_rsp.rem;
            end
         end
         ST_SRDA: begin
            sc_re = 1'b1;
         end
         ST_SRDB: begin
            sc_re    = 1'b1;
            sc_raddr = pick_ff[EDGE_AW-1:0];
            a_in     = sc_rdata;
         end
         ST_SEMIT: begin
            // The picked value is emitted; the picked slot takes the old entry i.
            if (can_put) begin
               rsp_valid_in = 1'b1;
               rsp_nb_in    = sc_rdata;
               rsp_cnt_in   = k_ff;
               rsp_st_in    = STS_OK;
               rsp_last_in  = (CNT_W'(i_ff + 1'b1) == k_ff);
               sc_we        = 1'b1;
               sc_waddr     = pick_ff[EDGE_AW-1:0];
               sc_wdata     = a_ff;
               i_in         = i_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         copy_v_ff     <= 1'b0;
         rng_ff        <= SEED_RESET;
         draw_limit_ff <= DRAW_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         copy_v_ff     <= copy_v_in;
         rng_ff        <= rng_in;
         draw_limit_ff <= draw_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      node_ff     <= node_in;
      begin_ff    <= begin_in;
      end_ff      <= end_in;
      cap_ff      <= cap_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      i_ff        <= i_in;
      pick_ff     <= pick_in;
      a_ff        <= a_in;
      cw_addr_ff  <= cw_addr_in;
      stat_ff     <= stat_in;
      rsp_nb_ff   <= rsp_nb_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.neighbor = rsp_nb_ff;
   assign rsp_ch.count    = rsp_cnt_ff;
   assign rsp_ch.status   = rsp_st_ff;
   assign rsp_ch.last     = rsp_last_ff;

   csr_ns_ram #(.WIDTH(IDX_W), .DEPTH(OFF_DEPTH)) u_offset_ram (
      .clock (clock),
      .we    (off_we),
      .waddr (off_waddr),
      .wdata (req_ch.value),
      .re    (off_re),
      .raddr (off_raddr),
      .rdata (off_rdata)
   );

   csr_ns_ram #(.WIDTH(NB_W), .DEPTH(EDGES)) u_neighbor_ram (
      .clock (clock),
      .we    (nb_we),
      .waddr (nb_waddr),
      .wdata (req_ch.value[NB_W-1:0]),
      .re    (nb_re),
      .raddr (nb_raddr),
      .rdata (nb_rdata)
   );

   csr_ns_ram #(.WIDTH(NB_W), .DEPTH(EDGES)) u_scratch_ram (
      .clock (clock),
      .we    (sc_we),
      .waddr (sc_waddr),
      .wdata (sc_wdata),
      .re    (sc_re),
      .raddr (sc_raddr),
      .rdata (sc_rdata)
   );

   csr_ns_modu u_modu (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

   // The remainder must land inside the part of the list not yet drawn from.
   `CSR_NS_ASSERT_IMPL(a_rem_below_left, (state_ff == ST_SDIV) && mod_rsp.done, mod_rsp.rem < left_cnt, "remainder not below remaining count")
   // A picked slot stays between the current step and the node's degree.
   `CSR_NS_ASSERT_IMPL(a_pick_in_range, state_ff == ST_SRDA, (pick_ff >= i_ext) && (pick_ff < cap_ff), "shuffle pick out of range")
   // The shuffle never runs more steps than the clamped draw limit.
   `CSR_NS_ASSERT_IMPL(a_step_bound, state_ff == ST_SEMIT, i_ff < k_ff, "shuffle step beyond draw limit")
   // Starting a remainder step always follows a generator advance.
   `CSR_NS_ASSERT_NEXT(a_rng_advance, state_ff == ST_SRNG, rng_ff == xorshift32($past(rng_ff)), "generator did not advance")

endmodule
`default_nettype wire

/* sv/csr_ns_ram.sv */
`default_nettype none
module csr_ns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

/* sv/csr_ns_modu.sv */
`default_nettype none
module csr_ns_modu (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire csr_ns_pkg::mod_req_type  req,
   output csr_ns_pkg::mod_rsp_type       rsp
);
   import csr_ns_pkg::*;

   // Restoring remainder, one dividend bit per cycle.
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic [RND_W-1:0]   dvd_ff, dvd_in;
   logic [REM_W-1:0]   dsr_ff, dsr_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [REM_W:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[RND_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = REM_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[REM_W-1:0];
         end
         dvd_in = {dvd_ff[RND_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(RND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;
endmodule
`default_nettype wire
